// ===== rtl/core/ghacc_pkg.sv =====
`default_nettype none

package ghacc_pkg;

	localparam int unsigned BLOCK_W     = 128;
	localparam int unsigned HALF_W      = 64;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned S_DATA_W    = 136;
	localparam int unsigned M_DATA_W    = 128;
	localparam int unsigned APB_ADDR_W  = 4;
	localparam int unsigned APB_DATA_W  = 64;
	localparam int unsigned QUEUE_DEPTH = 4;

	// x^128 = x^7 + x^2 + x + 1, the same field as the reflected 0xe1 || 0^120 form
	localparam logic [7:0] GF_POLY = 8'h87;

	// register index as carried by paddr[3]
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	typedef struct packed {
		logic [BLOCK_W-1:0] blk;
		logic               upd;
		logic               last;
	} queue_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	typedef struct packed {
		logic pop;
		logic pop_last;
	} back_status_t;

	// gf(2^128) product in gcm bit order; word bit 127 is coefficient of x^0
	function automatic logic [BLOCK_W-1:0] gf_mul(
		input logic [BLOCK_W-1:0] x,
		input logic [BLOCK_W-1:0] h
	);
		logic [BLOCK_W-1:0]   a;
		logic [BLOCK_W-1:0]   b;
		logic [BLOCK_W-1:0]   term;
		logic [2*BLOCK_W-2:0] c;
		logic [BLOCK_W-2:0]   hh;
		logic [BLOCK_W+7:0]   d;
		logic [7:0]           g;
		logic [BLOCK_W-1:0]   r;
		logic [BLOCK_W-1:0]   z;
		int                   j;
		for (int i = 0; i < BLOCK_W; i++) begin
			a[i] = x[BLOCK_W-1-i];
			b[i] = h[BLOCK_W-1-i];
		end
		// each product bit is an and-xor tree over its own terms
		for (int k = 0; k < 2*BLOCK_W-1; k++) begin
			for (int i = 0; i < BLOCK_W; i++) begin
				j = k - i;
				term[i] = (j >= 0 && j < BLOCK_W) ? (a[i] & b[j[6:0]]) : 1'b0;
			end
			c[k] = ^term;
		end
		// first fold of the upper half, then fold the few bits that spill over
		hh = c[2*BLOCK_W-2:BLOCK_W];
		d  = {8'b0, c[BLOCK_W-1:0]};
		for (int p = 0; p < 8; p++) begin
			if (GF_POLY[p]) begin
				d = d ^ ({9'b0, hh} << p);
			end
		end
		g = d[BLOCK_W+7:BLOCK_W];
		r = d[BLOCK_W-1:0];
		for (int p = 0; p < 8; p++) begin
			if (GF_POLY[p]) begin
				r = r ^ ({120'b0, g} << p);
			end
		end
		for (int i = 0; i < BLOCK_W; i++) begin
			z[BLOCK_W-1-i] = r[i];
		end
		return z;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ghacc_front.sv =====
`default_nettype none

module ghacc_front (
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// block_high [63:0], block_low [127:64], byte_count [132:128], zero pad
	input  wire logic [ghacc_pkg::S_DATA_W-1:0]     s_tdata,
	// last_block
	input  wire logic                               s_tlast,
	input  wire ghacc_pkg::queue_status_t           q_status,
	output logic                                    push,
	output ghacc_pkg::queue_entry_t                 push_data
);

	logic [ghacc_pkg::BLOCK_W-1:0] word;
	logic [ghacc_pkg::BLOCK_W-1:0] masked;
	logic [ghacc_pkg::COUNT_W-1:0] byte_count;

	assign byte_count = s_tdata[132:128];
	assign word       = {s_tdata[63:0], s_tdata[127:64]};

	// byte b sits at the top of the word for b = 0; counts above 16 keep all
	always_comb begin
		for (int b = 0; b < ghacc_pkg::BLOCK_BYTES; b++) begin
			masked[ghacc_pkg::BLOCK_W-1-8*b -: 8] =
				(ghacc_pkg::COUNT_W'(b) < byte_count) ?
				word[ghacc_pkg::BLOCK_W-1-8*b -: 8] : 8'h00;
		end
	end

	assign s_tready       = !q_status.full;
	assign push_data.blk  = masked;
	assign push_data.upd  = (byte_count != '0);
	assign push_data.last = s_tlast;

	// an item with no bytes and no last flag changes nothing and is dropped here
	assign push = s_tvalid && s_tready && (push_data.upd || push_data.last);

endmodule

`default_nettype wire

// ===== rtl/core/ghacc_queue.sv =====
`default_nettype none

module ghacc_queue #(
	parameter int unsigned DEPTH = ghacc_pkg::QUEUE_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire ghacc_pkg::queue_entry_t   push_data,
	input  wire logic                      pop,
	output ghacc_pkg::queue_entry_t        head,
	output ghacc_pkg::queue_status_t       status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ghacc_pkg::queue_entry_t entries_q [DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]        count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = entries_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// ===== rtl/core/ghacc_back.sv =====
`default_nettype none

module ghacc_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [ghacc_pkg::BLOCK_W-1:0]     key,
	input  wire ghacc_pkg::queue_entry_t           head,
	input  wire ghacc_pkg::queue_status_t          q_status,
	output ghacc_pkg::back_status_t                status,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// tag_high [63:0], tag_low [127:64]
	output logic [ghacc_pkg::M_DATA_W-1:0]         m_tdata
);

	logic [ghacc_pkg::BLOCK_W-1:0] acc_q;
	logic [ghacc_pkg::BLOCK_W-1:0] tag_q;
	logic                          tvalid_q;
	logic [ghacc_pkg::BLOCK_W-1:0] product;
	logic [ghacc_pkg::BLOCK_W-1:0] acc_next;
	logic                          pop;

	assign product  = ghacc_pkg::gf_mul(acc_q ^ head.blk, key);
	assign acc_next = head.upd ? product : acc_q;

	// updates never wait on the output; only a tag waits for a free output register
	assign pop = !q_status.empty && (!head.last || !tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= head.last ? '0 : acc_next;
			end
			if (pop && head.last) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			tag_q <= acc_next;
		end
	end

	assign status.pop      = pop;
	assign status.pop_last = pop && head.last;
	assign m_tvalid        = tvalid_q;
	assign m_tdata         = {tag_q[ghacc_pkg::HALF_W-1:0],
		tag_q[ghacc_pkg::BLOCK_W-1:ghacc_pkg::HALF_W]};

endmodule

`default_nettype wire

// ===== rtl/core/ghash_accumulator_top.sv =====
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: block_high, block_low, byte_count; s_tlast
// m_        out  m_tvalid/m_tready    m_tdata: tag_high, tag_low
// apb       in   psel/penable/pready  key_high at 0x0, key_low at 0x8
//
// one block per cycle sustained while the queue is not full; the accumulator loop closes
// through a single full gf(2^128) multiply each cycle. a block reaches the queue at its
// accept edge, and its tag is registered for m_tdata when the last entry is popped.
// reset clears keys, accumulator, queue and output valid; no clearing pass.
// a stalled tag holds only the back end on a last block; the queue absorbs
// up to QUEUE_DEPTH blocks before s_tready drops.
`default_nettype none

module ghash_accumulator_top #(
	parameter int unsigned QUEUE_DEPTH = ghacc_pkg::QUEUE_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// block_high [63:0], block_low [127:64], byte_count [132:128], zero pad
	input  wire logic [ghacc_pkg::S_DATA_W-1:0]      s_tdata,
	// last_block
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// tag_high [63:0], tag_low [127:64]
	output logic [ghacc_pkg::M_DATA_W-1:0]           m_tdata,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ghacc_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [ghacc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ghacc_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                     pready
);

	logic [ghacc_pkg::HALF_W-1:0] key_high_q;
	logic [ghacc_pkg::HALF_W-1:0] key_low_q;
	logic                         cfg_write;

	logic                         push;
	ghacc_pkg::queue_entry_t      push_data;
	ghacc_pkg::queue_entry_t      head;
	ghacc_pkg::queue_status_t     q_status;
	ghacc_pkg::back_status_t      back_status;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_write) begin
			unique case (paddr[3])
				ghacc_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				ghacc_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
				default:                 key_high_q <= key_high_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			ghacc_pkg::REG_KEY_HIGH: prdata = key_high_q;
			ghacc_pkg::REG_KEY_LOW:  prdata = key_low_q;
			default:                 prdata = '0;
		endcase
	end

	ghacc_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	ghacc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (back_status.pop),
		.head      (head),
		.status    (q_status)
	);

	ghacc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      ({key_high_q, key_low_q}),
		.head     (head),
		.q_status (q_status),
		.status   (back_status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a last block taken in must be waiting in the queue next cycle
	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !q_status.empty)
		else $error("last item accepted but queue empty");

	// a tag appears only after a last entry left the queue
	a_tag_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(back_status.pop_last))
		else $error("tag valid without a last entry");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.pop |-> !q_status.empty)
		else $error("pop from empty queue");

	// back end never drops a tag that is still waiting
	a_tag_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !back_status.pop_last)
		else $error("tag overwritten while stalled");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_W      = ghacc_pkg::HALF_W;
	localparam int COUNT_W     = ghacc_pkg::COUNT_W;
	localparam int BLOCK_BYTES = ghacc_pkg::BLOCK_BYTES;
	localparam int S_DATA_W    = ghacc_pkg::S_DATA_W;
	localparam int M_DATA_W    = ghacc_pkg::M_DATA_W;
	localparam int APB_ADDR_W  = ghacc_pkg::APB_ADDR_W;
	localparam int APB_DATA_W  = ghacc_pkg::APB_DATA_W;
	localparam int QUEUE_DEPTH = ghacc_pkg::QUEUE_DEPTH;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// queue plus back end, with margin, for blocks that leave no tag behind
	localparam int DRAIN_CYCLES = 4*QUEUE_DEPTH + 8;
	localparam bit [HALF_W-1:0] GF_R = 64'hE100000000000000;
	localparam bit [HALF_W-1:0] ONES = '1;

	typedef struct packed {
		bit [HALF_W-1:0] hi;
		bit [HALF_W-1:0] lo;
	} tag_t;

	class tag_predictor;
		bit [HALF_W-1:0] key_hi;
		bit [HALF_W-1:0] key_lo;
		bit [HALF_W-1:0] acc_hi;
		bit [HALF_W-1:0] acc_lo;
		tag_t pending_tags[$];
		int fail_count;

		task report(string what);
			if (fail_count < 100) begin
				$display("tb_top: mismatch: %s", what);
			end
			fail_count++;
		endtask

		function void set_key(logic sel, bit [HALF_W-1:0] v);
			if (sel == ghacc_pkg::REG_KEY_HIGH) begin
				key_hi = v;
			end else begin
				key_lo = v;
			end
		endfunction

		// keeps the k leading bytes of a big-endian word
		function bit [HALF_W-1:0] lead_bytes(int k);
			if (k == 0) begin
				return '0;
			end
			if (k >= 8) begin
				return ONES;
			end
			return ONES << (64 - 8*k);
		endfunction

		// acc = (acc ^ x) * H, bit 0 of the field is the msb of the high half
		function void fold_in(bit [HALF_W-1:0] xh, bit [HALF_W-1:0] xl);
			bit [HALF_W-1:0] ah;
			bit [HALF_W-1:0] al;
			bit [HALF_W-1:0] vh;
			bit [HALF_W-1:0] vl;
			bit [HALF_W-1:0] rh;
			bit [HALF_W-1:0] rl;
			bit              b;
			bit              lsb;
			ah = acc_hi ^ xh;
			al = acc_lo ^ xl;
			vh = key_hi;
			vl = key_lo;
			rh = '0;
			rl = '0;
			for (int i = 0; i < 128; i++) begin
				b = (i < 64) ? ah[63-i] : al[127-i];
				if (b) begin
					rh ^= vh;
					rl ^= vl;
				end
				lsb = vl[0];
				vl  = {vh[0], vl[63:1]};
				vh  = (vh >> 1) ^ (lsb ? GF_R : '0);
			end
			acc_hi = rh;
			acc_lo = rl;
		endfunction

		function void take_block(bit [HALF_W-1:0] bh, bit [HALF_W-1:0] bl,
			bit [COUNT_W-1:0] cnt, bit last);
			int   n;
			tag_t t;
			n = (cnt > BLOCK_BYTES) ? BLOCK_BYTES : int'(cnt);
			if (n != 0) begin
				fold_in(bh & lead_bytes(n > 8 ? 8 : n), bl & lead_bytes(n > 8 ? n - 8 : 0));
			end
			if (last) begin
				t.hi = acc_hi;
				t.lo = acc_lo;
				pending_tags.push_back(t);
				acc_hi = '0;
				acc_lo = '0;
			end
		endfunction

		task check_tag(bit [HALF_W-1:0] hi, bit [HALF_W-1:0] lo);
			tag_t t;
			if (pending_tags.size() == 0) begin
				report($sformatf("unexpected tag %h_%h", hi, lo));
				return;
			end
			t = pending_tags.pop_front();
			if (hi != t.hi) begin
				report($sformatf("tag_high %h, want %h", hi, t.hi));
			end
			if (lo != t.lo) begin
				report($sformatf("tag_low %h, want %h", lo, t.lo));
			end
		endtask

		function int outstanding();
			return pending_tags.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	tag_predictor pred;
	bit           quiet_mode;
	int           accepted_blocks;
	int           cycle_count = 0;

	ghash_accumulator_top i_dut (.*);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	function automatic int idle_span();
		int r;
		if (quiet_mode) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic send_block(bit [HALF_W-1:0] bh, bit [HALF_W-1:0] bl,
		bit [COUNT_W-1:0] cnt, bit last);
		int gap;
		gap = idle_span();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, cnt, bl, bh};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		accepted_blocks++;
	endtask

	// hold the sender until every tag is back and the queue has emptied
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pred.outstanding() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_key(logic sel, bit [HALF_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pred.set_key(sel, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_keys(bit [HALF_W-1:0] hi, bit [HALF_W-1:0] lo);
		write_key(ghacc_pkg::REG_KEY_HIGH, hi);
		write_key(ghacc_pkg::REG_KEY_LOW, lo);
	endtask

	task automatic send_message(int nblk);
		bit [HALF_W-1:0]  bh;
		bit [HALF_W-1:0]  bl;
		bit [COUNT_W-1:0] cnt;
		int               r;
		for (int i = 0; i < nblk; i++) begin
			bh = {$urandom, $urandom};
			bl = {$urandom, $urandom};
			r  = $urandom_range(0, 99);
			if (i == nblk - 1 && $urandom_range(0, 99) < 45) begin
				cnt = COUNT_W'($urandom_range(1, 15));
			end else begin
				cnt = COUNT_W'(BLOCK_BYTES);
			end
			if (r < 4) begin
				cnt = '0;
			end else if (r < 6) begin
				cnt = COUNT_W'($urandom_range(17, 31));
			end else if (r < 8) begin
				bh = (r == 6) ? ONES : '0;
				bl = (r == 6) ? ONES : '0;
			end
			send_block(bh, bl, cnt, i == nblk - 1);
		end
	endtask

	task automatic random_phase(int n);
		int target;
		int r;
		target = accepted_blocks + n;
		while (accepted_blocks < target) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				send_message($urandom_range(1, 6));
			end else if (r < 98) begin
				// stray blocks that may break a message
				send_block({$urandom, $urandom}, {$urandom, $urandom},
					COUNT_W'($urandom_range(0, 16)), 1'($urandom_range(0, 1)));
			end else begin
				drain();
			end
		end
	endtask

	task automatic directed();
		int cnts[5] = '{1, 7, 8, 9, 15};
		send_block(ONES, ONES, COUNT_W'(16), 1'b0);
		send_block('0, '0, COUNT_W'(16), 1'b1);
		// zero count on a last block still emits the running sum
		send_block({$urandom, $urandom}, {$urandom, $urandom}, COUNT_W'(16), 1'b0);
		send_block(ONES, ONES, '0, 1'b1);
		send_block(ONES, ONES, '0, 1'b1);
		// partial blocks: padding must clear the trailing bytes
		foreach (cnts[i]) begin
			send_block(ONES, ONES, COUNT_W'(cnts[i]), 1'b1);
		end
		// counts past sixteen saturate
		send_block(ONES, ONES, COUNT_W'(17), 1'b1);
		send_block(ONES, ONES, COUNT_W'(31), 1'b1);
		send_block(ONES, ONES, '0, 1'b0);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210, COUNT_W'(16), 1'b1);
		send_block(64'h8000000000000000, 64'h1, COUNT_W'(16), 1'b0);
		send_block('0, ONES, COUNT_W'(16), 1'b1);
	endtask

	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			n = idle_span();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 7)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else if (arst_n) begin
			if (m_tvalid && m_tready) begin
				pred.check_tag(m_tdata[HALF_W-1:0], m_tdata[2*HALF_W-1:HALF_W]);
			end
			if (s_tvalid && s_tready) begin
				pred.take_block(s_tdata[HALF_W-1:0], s_tdata[2*HALF_W-1:HALF_W],
					s_tdata[2*HALF_W+COUNT_W-1:2*HALF_W], s_tlast);
			end
		end
	end

	initial begin
		pred            = new();
		quiet_mode      = 1'b0;
		accepted_blocks = 0;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tlast         = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// keys still at reset: every tag is zero
		random_phase(40);
		drain();
		set_keys(ONES, ONES);
		directed();
		random_phase(280);
		drain();
		// identity key: the tag is the xor of the padded blocks
		set_keys(64'h8000000000000000, '0);
		random_phase(250);
		drain();
		set_keys('0, 64'h1);
		random_phase(250);
		drain();
		for (int p = 0; p < 3; p++) begin
			set_keys({$urandom, $urandom}, {$urandom, $urandom});
			quiet_mode = (p == 1);
			random_phase(230);
			drain();
		end
		quiet_mode = 1'b0;

		if (pred.fail_count == 0 && pred.outstanding() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
